// File: rtl/stable_sorted_priority_queue_defines.svh
// Assertion macros for the stable sorted priority queue.
// Included by the top level; needs i_clk and i_rst_n in the including scope.
`ifndef STABLE_SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SSPQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sspq assertion failed");
`define SSPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sspq assertion failed");
`else
`define SSPQ_ASSERT_NOW(label, ante, cons)
`define SSPQ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/sspq_pkg.sv
// Types and constants of the stable sorted priority queue.
// No dependencies.
`default_nettype none

package sspq_pkg;

    localparam int CAPACITY = 16;
    localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW       = $clog2(CAPACITY + 1);
    localparam int SW       = 24;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        logic        op;
        logic [15:0] entry_id;
        logic [7:0]  urgency;
    } t_in;

    typedef struct packed {
        t_status     status;
        logic [15:0] out_id;
        logic [7:0]  out_urgency;
        logic [4:0]  occupancy;
    } t_out;

    typedef struct packed {
        logic [15:0] entry_id;
        logic [7:0]  urgency;
    } t_slot;

endpackage

`default_nettype wire

// File: rtl/sspq_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module sspq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 24,
    parameter int ADDRW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [ADDRW-1:0] i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [ADDRW-1:0] i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: rtl/stable_sorted_priority_queue.sv
// Insert into a non-empty queue walks S_CMP past each of the k stored entries with a larger
// urgency (0 to 15), shifting it, then writes the new entry; remove passes through S_POP;
// full insert, empty remove and empty insert go straight to S_DONE. One transaction at a
// time, taken again in the cycle after the result register loads; a stalled result holds the
// block until it is taken. Insert time is set by the tail-to-head compare-and-shift walk,
// one entry per cycle. Reset (synchronous, active low) empties the queue; slot contents are not cleared.
`default_nettype none
`include "stable_sorted_priority_queue_defines.svh"

module stable_sorted_priority_queue
    import sspq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out      o_out_data
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CMP  = 5'b00010,
        S_PUT  = 5'b00100,
        S_POP  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == LAST) ? '0 : AW'(p + 1'b1);
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        return (p == '0) ? LAST : AW'(p - 1'b1);
    endfunction

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [CW-1:0] r_left, n_left;
    t_slot         r_new, n_new;
    t_out          r_res, n_res;
    logic          r_out_valid, n_out_valid;
    t_out          r_out, n_out;

    logic          w_accept;
    logic          w_out_free;
    logic          w_full;
    logic [AW:0]   w_tail_sum;
    logic [AW-1:0] w_tail;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_slot         w_wdata;
    logic [AW-1:0] w_raddr;
    logic [SW-1:0] w_rdata;
    t_slot         w_rslot;
    logic [CW-1:0] w_count_inc;

    sspq_ram #(
        .DEPTH(CAPACITY),
        .WIDTH(SW)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_rslot     = t_slot'(w_rdata);
    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_full      = (r_count == CW'(CAPACITY));
    assign w_count_inc = CW'(r_count + 1'b1);
    assign w_tail_sum  = (AW + 1)'(r_head) + (AW + 1)'(r_count - 1'b1);
    assign w_tail      = (w_tail_sum >= (AW + 1)'(CAPACITY))
                       ? AW'(w_tail_sum - (AW + 1)'(CAPACITY)) : AW'(w_tail_sum);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_head      = r_head;
        n_rd_ptr    = r_rd_ptr;
        n_wr_ptr    = r_wr_ptr;
        n_left      = r_left;
        n_new       = r_new;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        w_we        = 1'b0;
        w_waddr     = r_wr_ptr;
        w_wdata     = r_new;
        w_raddr     = r_rd_ptr;

        unique case (r_state)
            S_IDLE: begin
                w_raddr = (i_in_data.op == OP_REMOVE) ? r_head : w_tail;
                if (w_accept) begin
                    n_new = '{entry_id: i_in_data.entry_id, urgency: i_in_data.urgency};
                    n_res = '{status: ST_INSERTED, out_id: '0, out_urgency: '0,
                              occupancy: 5'(r_count)};
                    n_state = S_DONE;
                    if (i_in_data.op == OP_INSERT) begin
                        if (w_full) begin
                            n_res.status = ST_FULL;
                        end else if (r_count == '0) begin
                            w_we            = 1'b1;
                            w_waddr         = r_head;
                            w_wdata         = n_new;
                            n_count         = w_count_inc;
                            n_res.occupancy = 5'(w_count_inc);
                        end else begin
                            n_rd_ptr = w_tail;
                            n_wr_ptr = ptr_inc(w_tail);
                            n_left   = r_count;
                            n_state  = S_CMP;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_res.status = ST_EMPTY;
                        end else begin
                            n_state = S_POP;
                        end
                    end
                end
            end
            S_CMP: begin
                w_raddr = ptr_dec(r_rd_ptr);
                w_we    = 1'b1;
                if (w_rslot.urgency > r_new.urgency) begin
                    w_wdata  = w_rslot;
                    n_wr_ptr = r_rd_ptr;
                    n_rd_ptr = ptr_dec(r_rd_ptr);
                    n_left   = CW'(r_left - 1'b1);
                    n_state  = (r_left == CW'(1)) ? S_PUT : S_CMP;
                end else begin
                    n_count         = w_count_inc;
                    n_res.occupancy = 5'(w_count_inc);
                    n_state         = S_DONE;
                end
            end
            S_PUT: begin
                w_we            = 1'b1;
                n_count         = w_count_inc;
                n_res.occupancy = 5'(w_count_inc);
                n_state         = S_DONE;
            end
            S_POP: begin
                n_res.status      = ST_REMOVED;
                n_res.out_id      = w_rslot.entry_id;
                n_res.out_urgency = w_rslot.urgency;
                n_res.occupancy   = 5'(CW'(r_count - 1'b1));
                n_count           = CW'(r_count - 1'b1);
                n_head            = ptr_inc(r_head);
                n_state           = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_head      <= n_head;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ptr <= n_rd_ptr;
        r_wr_ptr <= n_wr_ptr;
        r_left   <= n_left;
        r_new    <= n_new;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `SSPQ_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(CAPACITY))
    `SSPQ_ASSERT_NEXT(a_accept_leaves_idle, w_accept, r_state != S_IDLE)
    `SSPQ_ASSERT_NOW(a_walk_has_entries, r_state == S_CMP, r_left != '0)
    `SSPQ_ASSERT_NEXT(a_pop_decrements, r_state == S_POP, r_count == CW'($past(r_count) - 1'b1))

endmodule

`default_nettype wire

// File: verif/sspq_checker.sv
// Scoreboard for the stable sorted priority queue: tracks its own sorted copy of the queue,
// predicts one result per accepted request and checks each accepted response against it.
// Depends on sspq_pkg for the payload structs, opcodes and status codes.
`default_nettype none

module sspq_checker
    import sspq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_in_stall,
    input  wire t_in  i_in_data,
    input  wire logic i_out_valid,
    input  wire logic i_out_stall,
    input  wire t_out i_out_data,
    output int        o_mismatches,
    output int        o_pending,
    output int        o_checked,
    output int        o_full_seen,
    output int        o_empty_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    t_slot sorted_slots [CAPACITY];
    int    held = 0;
    t_out  pending_results [$];
    int    mismatch_count = 0;
    int    checked_count  = 0;
    int    full_count     = 0;
    int    empty_count    = 0;

    function automatic t_out apply_request(t_in req);
        t_out res;
        int   pos;
        int   i;
        res = '0;
        if (req.op == OP_INSERT) begin
            if (held >= CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < held && sorted_slots[pos].urgency <= req.urgency)
                    pos++;
                for (i = held; i > pos; i--)
                    sorted_slots[i] = sorted_slots[i - 1];
                sorted_slots[pos].entry_id = req.entry_id;
                sorted_slots[pos].urgency  = req.urgency;
                held++;
                res.status = ST_INSERTED;
            end
        end else begin
            if (held == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.out_id      = sorted_slots[0].entry_id;
                res.out_urgency = sorted_slots[0].urgency;
                for (i = 0; i + 1 < held; i++)
                    sorted_slots[i] = sorted_slots[i + 1];
                held--;
                res.status = ST_REMOVED;
            end
        end
        res.occupancy = 5'(held);
        return res;
    endfunction

    task automatic compare_field(string field, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            held = 0;
            pending_results.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                pending_results.push_back(apply_request(i_in_data));
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected response 0x%0h, nothing outstanding",
                             $time, i_out_data);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    compare_field("status", 16'(want.status), 16'(i_out_data.status));
                    compare_field("out_id", want.out_id, i_out_data.out_id);
                    compare_field("out_urgency", 16'(want.out_urgency),
                                  16'(i_out_data.out_urgency));
                    compare_field("occupancy", 16'(want.occupancy),
                                  16'(i_out_data.occupancy));
                    checked_count++;
                    if (want.status == ST_FULL)
                        full_count++;
                    if (want.status == ST_EMPTY)
                        empty_count++;
                end
            end
        end
        o_pending    <= pending_results.size();
        o_mismatches <= mismatch_count;
        o_checked    <= checked_count;
        o_full_seen  <= full_count;
        o_empty_seen <= empty_count;
    end

endmodule

`default_nettype wire

// File: verif/stable_sorted_priority_queue_tb.sv
// Top of the priority queue testbench: clock, reset, request stimulus and response stalls.
// Instantiates stable_sorted_priority_queue and sspq_checker; depends on sspq_pkg.
`default_nettype none

module stable_sorted_priority_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sspq_pkg::*;

    localparam int IDLE_PCT       = 38;
    localparam int RANDOM_ITEMS   = 1375;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 40;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in_data   = '0;
    logic i_out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out_data;

    int mismatches;
    int pending;
    int checked;
    int full_seen;
    int empty_seen;

    bit quiet = 1'b0;
    int inserts_sent = 0;
    int removes_sent = 0;
    int stuck_cycles = 0;

    stable_sorted_priority_queue i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    sspq_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_full_seen  (full_seen),
        .o_empty_seen (empty_seen)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no transaction for %0d cycles", $time, stuck_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic t_in make_request(logic op, logic [15:0] id, logic [7:0] urg);
        t_in req;
        req.op       = op;
        req.entry_id = id;
        req.urgency  = urg;
        return req;
    endfunction

    task automatic send(t_in req);
        if (!quiet) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        if (req.op == OP_INSERT)
            inserts_sent++;
        else
            removes_sent++;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // hold requests back until every outstanding response has been taken
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        logic [15:0] seed_ids  [16];
        logic [7:0]  seed_urgs [16];
        int          insert_pct;
        logic        op;
        logic [7:0]  urg;

        seed_ids  = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555, 16'h0001, 16'h0002,
                      16'h0003, 16'h0004, 16'h0005, 16'h0006, 16'h0007, 16'h0008,
                      16'h0009, 16'h000A, 16'h000B, 16'h000C};
        seed_urgs = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h80, 8'h80, 8'h80, 8'h00,
                      8'hFF, 8'h7F, 8'h80, 8'h01, 8'hFE, 8'h80, 8'h55, 8'h00};
        insert_pct = 50;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty pop, fill with extremes and ties, overflow, partial drain
        send(make_request(OP_REMOVE, 16'hFFFF, 8'hFF));
        for (int i = 0; i < 16; i++)
            send(make_request(OP_INSERT, seed_ids[i], seed_urgs[i]));
        send(make_request(OP_INSERT, 16'h1234, 8'h00));
        repeat (7) send(make_request(OP_REMOVE, 16'($urandom), 8'($urandom)));
        drain();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(2))
                    0:       insert_pct = 85;
                    1:       insert_pct = 50;
                    default: insert_pct = 15;
                endcase
            end
            quiet = (n >= 500 && n < 750);
            if (n % 250 == 249)
                drain();
            op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
            case ($urandom_range(3))
                0:       urg = 8'($urandom_range(3));
                1:       urg = 8'($urandom_range(255));
                2:       urg = $urandom_range(1) ? 8'hFF : 8'h00;
                default: urg = 8'($urandom_range(135, 120));
            endcase
            send(make_request(op, 16'($urandom), urg));
        end
        quiet = 1'b0;

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d inserts and %0d removes, %0d responses checked",
                 inserts_sent, removes_sent, checked);
        $display("Full queue rejected %0d inserts, empty queue answered %0d removes",
                 full_seen, empty_seen);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
